// File: rtl/assert_macros.svh
// Assertion macros shared by the cache tag RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	`ASSERT_AT(lbl, clk, rst_n, !(cond), msg)
`else
`define ASSERT_AT(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// File: rtl/sacl_pkg.sv
// Types, constants and helpers for the set-associative LRU cache tag block.
`default_nettype none
package sacl_pkg;
	localparam int ADDR_W     = 32;
	localparam int CNT_W      = 32;
	localparam int SET_OUT_W  = 7;
	localparam int WAY_OUT_W  = 2;
	localparam int MODE_W     = 2;
	localparam int SHIFT_W    = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	localparam int PAGE_BITS  = 12;
	localparam int HASH_SH_HI = 16;
	localparam int HASH_SH_LO = 2;
	localparam int PPN_TOP    = 30;
	localparam logic [ADDR_W-1:0] PPN_MASK =
		((ADDR_W'(1) << PPN_TOP) - ADDR_W'(1)) & ~((ADDR_W'(1) << PAGE_BITS) - ADDR_W'(1));
	localparam logic [ADDR_W-1:0] PAGE_MASK = (ADDR_W'(1) << PAGE_BITS) - ADDR_W'(1);

	localparam logic [MODE_W-1:0] XLATE_VIRT = 2'd0;
	localparam logic [MODE_W-1:0] XLATE_PHYS = 2'd1;
	localparam logic [MODE_W-1:0] XLATE_VIPT = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SHIFT = 2'd1;

	localparam logic [MODE_W-1:0]  MODE_RESET  = XLATE_VIRT;
	localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd12;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_XLATE,
		ST_INDEX,
		ST_SCAN,
		ST_UPDATE
	} state_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		return (c == {CNT_W{1'b1}}) ? c : c + CNT_W'(1);
	endfunction
endpackage
`default_nettype wire

// File: rtl/sacl_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sacl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// File: rtl/set_assoc_lru_cache_tags.sv
// Top level: set-associative cache tag lookup with LRU replacement and counters.
// Usage:
//   Command channel: drive addr and action (0 read, 1 write) with start; the word is
//   taken at a rising edge with start high and busy low. busy stays high until the
//   lookup finishes.
//   Result: hit, set_index, way_used, request_count and hit_count show for exactly
//   one cycle with done high. The receiver cannot stall; results must be taken then.
//   Config: cfg_valid/cfg_ready write channel, cfg_index 0 translate_mode, 1
//   index_shift. cfg_ready is always high; write only while idle.
// Sequence: accept, then the hash, translate and index states, then the scan reads
//   one way per cycle from the tag RAM through a single shared tag comparator, with
//   the tag read registered, then an update. A hit ends the scan at the matching way;
//   a miss scans every way and takes the LRU way. A new word can be taken in the
//   cycle done is high.
// Reset: a clearing pass writes every set of the valid/LRU RAM, one set per cycle,
//   with busy high. Config writes are taken during the pass.
//   Tag RAM contents are undefined until written; valid bits mask them.
`default_nettype none
`include "assert_macros.svh"
module set_assoc_lru_cache_tags #(
	parameter int SET_BITS = 7,
	parameter int WAYS     = 4
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [sacl_pkg::ADDR_W-1:0]       addr,
	input  wire logic                              action,
	output logic                                   done,
	output logic                                   hit,
	output logic      [sacl_pkg::SET_OUT_W-1:0]    set_index,
	output logic      [sacl_pkg::WAY_OUT_W-1:0]    way_used,
	output logic      [sacl_pkg::CNT_W-1:0]        request_count,
	output logic      [sacl_pkg::CNT_W-1:0]        hit_count,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [sacl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [sacl_pkg::CFG_DATA_W-1:0]   cfg_data
);
	localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int TAG_W   = sacl_pkg::ADDR_W - SET_BITS;
	localparam int META_W  = WAYS + WAYS * WAY_W;
	localparam int SETS    = 1 << SET_BITS;
	localparam int TADDR_W = SET_BITS + WAY_W;

	sacl_pkg::state_t state_q, state_d;

	logic [sacl_pkg::MODE_W-1:0]  mode_q;
	logic [sacl_pkg::SHIFT_W-1:0] shift_q;

	logic [sacl_pkg::ADDR_W-1:0] va_q, sum_q, pa_q;
	logic                        write_q;
	logic [SET_BITS-1:0]         set_q, clear_q;
	logic [TAG_W-1:0]            tag_q;
	logic [WAY_W-1:0]            rd_way_q, cmp_way_q, way_sel_q;
	logic                        cmp_q, hit_sel_q;
	logic [sacl_pkg::CNT_W-1:0]  rd_req_q, wr_req_q, rd_hit_q, wr_hit_q;

	// RAM ports
	logic               tag_we, tag_re;
	logic [TADDR_W-1:0] tag_waddr, tag_raddr;
	logic [TAG_W-1:0]   tag_rdata;
	logic               meta_we, meta_re;
	logic [SET_BITS-1:0] meta_waddr;
	logic [META_W-1:0]  meta_wdata, meta_rdata;

	sacl_ram #(.WIDTH(TAG_W), .DEPTH(1 << TADDR_W)) u_tag_ram (
		.clk   (clk),
		.we    (tag_we),
		.waddr (tag_waddr),
		.wdata (tag_q),
		.re    (tag_re),
		.raddr (tag_raddr),
		.rdata (tag_rdata)
	);

	sacl_ram #(.WIDTH(META_W), .DEPTH(SETS)) u_meta_ram (
		.clk   (clk),
		.we    (meta_we),
		.waddr (meta_waddr),
		.wdata (meta_wdata),
		.re    (meta_re),
		.raddr (set_q),
		.rdata (meta_rdata)
	);

	// Decode the set row: valid bits low, LRU order above (position 0 is LRU).
	logic [WAYS-1:0]  valid_cur;
	logic [WAY_W-1:0] lru_cur [WAYS];
	logic [WAY_W-1:0] lru_new [WAYS];
	logic [WAY_W-1:0] mru_pos;
	logic             pos_found;
	logic [META_W-1:0] meta_upd, meta_init;

	always_comb begin
		valid_cur = meta_rdata[WAYS-1:0];
		for (int i = 0; i < WAYS; i++) begin
			lru_cur[i] = meta_rdata[WAYS + i*WAY_W +: WAY_W];
		end
	end

	// Locate the chosen way in the order, then shift the younger ones down.
	always_comb begin
		mru_pos   = '0;
		pos_found = 1'b0;
		for (int i = 0; i < WAYS; i++) begin
			if (!pos_found && lru_cur[i] == way_sel_q) begin
				mru_pos   = WAY_W'(i);
				pos_found = 1'b1;
			end
		end
		for (int j = 0; j < WAYS - 1; j++) begin
			lru_new[j] = (WAY_W'(j) < mru_pos) ? lru_cur[j] : lru_cur[j+1];
		end
		lru_new[WAYS-1] = way_sel_q;
	end

	always_comb begin
		meta_upd  = '0;
		meta_init = '0;
		meta_upd[WAYS-1:0] = valid_cur | (WAYS'(1) << way_sel_q);
		for (int i = 0; i < WAYS; i++) begin
			meta_upd[WAYS + i*WAY_W +: WAY_W]  = lru_new[i];
			meta_init[WAYS + i*WAY_W +: WAY_W] = WAY_W'(i);
		end
	end

	// Shared tag comparator
	logic cmp_match, scan_last, scan_done;
	assign cmp_match = cmp_q && valid_cur[cmp_way_q] && (tag_rdata == tag_q);
	assign scan_last = cmp_q && (cmp_way_q == WAY_W'(WAYS - 1));
	assign scan_done = cmp_match || scan_last;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sacl_pkg::ST_CLEAR: begin
				if (clear_q == SET_BITS'(SETS - 1)) state_d = sacl_pkg::ST_IDLE;
			end
			sacl_pkg::ST_IDLE: begin
				if (start) state_d = sacl_pkg::ST_HASH;
			end
			sacl_pkg::ST_HASH:   state_d = sacl_pkg::ST_XLATE;
			sacl_pkg::ST_XLATE:  state_d = sacl_pkg::ST_INDEX;
			sacl_pkg::ST_INDEX:  state_d = sacl_pkg::ST_SCAN;
			sacl_pkg::ST_SCAN: begin
				if (scan_done) state_d = sacl_pkg::ST_UPDATE;
			end
			sacl_pkg::ST_UPDATE: state_d = sacl_pkg::ST_IDLE;
			default:             state_d = sacl_pkg::ST_IDLE;
		endcase
	end

	// RAM controls and handshake outputs
	always_comb begin
		busy       = (state_q != sacl_pkg::ST_IDLE);
		cfg_ready  = 1'b1;
		tag_re     = (state_q == sacl_pkg::ST_SCAN);
		tag_raddr  = {set_q, rd_way_q};
		tag_we     = (state_q == sacl_pkg::ST_UPDATE) && !hit_sel_q;
		tag_waddr  = {set_q, way_sel_q};
		meta_re    = (state_q == sacl_pkg::ST_SCAN) && !cmp_q;
		meta_we    = 1'b0;
		meta_waddr = set_q;
		meta_wdata = meta_upd;
		unique case (state_q)
			sacl_pkg::ST_CLEAR: begin
				meta_we    = 1'b1;
				meta_waddr = clear_q;
				meta_wdata = meta_init;
			end
			sacl_pkg::ST_UPDATE: meta_we = 1'b1;
			default: ;
		endcase
	end

	// Page hash terms and index/tag extraction
	logic [sacl_pkg::ADDR_W-1:0] vpn, hash_h, pa_d, ia, ta, set_full, tag_full;
	logic [5:0]                  tsh;
	always_comb begin
		vpn    = va_q >> sacl_pkg::PAGE_BITS;
		hash_h = sum_q + (~vpn | (vpn << sacl_pkg::HASH_SH_LO));
		pa_d   = ((hash_h & sacl_pkg::PPN_MASK) << sacl_pkg::PAGE_BITS)
			+ (va_q & sacl_pkg::PAGE_MASK);
		unique case (mode_q)
			sacl_pkg::XLATE_PHYS: begin
				ia = pa_q;
				ta = pa_q;
			end
			sacl_pkg::XLATE_VIPT: begin
				ia = va_q;
				ta = pa_q;
			end
			default: begin
				ia = va_q;
				ta = va_q;
			end
		endcase
		set_full = ia >> shift_q;
		tsh      = {1'b0, shift_q} + 6'(SET_BITS);
		tag_full = (tsh >= 6'd32) ? '0 : (ta >> tsh[4:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sacl_pkg::ST_CLEAR;
			clear_q  <= '0;
			mode_q   <= sacl_pkg::MODE_RESET;
			shift_q  <= sacl_pkg::SHIFT_RESET;
			cmp_q    <= 1'b0;
			done     <= 1'b0;
			rd_req_q <= '0;
			wr_req_q <= '0;
			rd_hit_q <= '0;
			wr_hit_q <= '0;
		end else begin
			state_q <= state_d;
			done    <= (state_q == sacl_pkg::ST_UPDATE);
			if (state_q == sacl_pkg::ST_CLEAR) clear_q <= clear_q + SET_BITS'(1);
			if (cfg_valid) begin
				if (cfg_index == sacl_pkg::CFG_MODE) mode_q <= cfg_data[sacl_pkg::MODE_W-1:0];
				if (cfg_index == sacl_pkg::CFG_SHIFT) shift_q <= cfg_data;
			end
			if (state_q == sacl_pkg::ST_SCAN) begin
				cmp_q <= 1'b1;
			end else begin
				cmp_q <= 1'b0;
			end
			if (state_q == sacl_pkg::ST_UPDATE) begin
				if (write_q) begin
					wr_req_q <= sacl_pkg::sat_inc(wr_req_q);
					if (hit_sel_q) wr_hit_q <= sacl_pkg::sat_inc(wr_hit_q);
				end else begin
					rd_req_q <= sacl_pkg::sat_inc(rd_req_q);
					if (hit_sel_q) rd_hit_q <= sacl_pkg::sat_inc(rd_hit_q);
				end
			end
		end
	end

	// Datapath registers
	logic [31:0] set_ext, way_ext;
	assign set_ext = 32'(set_q);
	assign way_ext = 32'(way_sel_q);

	always_ff @(posedge clk) begin
		unique case (state_q)
			sacl_pkg::ST_IDLE: begin
				va_q    <= addr;
				write_q <= action;
			end
			sacl_pkg::ST_HASH: begin
				sum_q <= (~vpn ^ (vpn << sacl_pkg::HASH_SH_HI))
					+ (vpn & (vpn << sacl_pkg::HASH_SH_HI));
			end
			sacl_pkg::ST_XLATE: pa_q <= pa_d;
			sacl_pkg::ST_INDEX: begin
				set_q    <= set_full[SET_BITS-1:0];
				tag_q    <= tag_full[TAG_W-1:0];
				rd_way_q <= '0;
			end
			sacl_pkg::ST_SCAN: begin
				rd_way_q  <= rd_way_q + WAY_W'(1);
				cmp_way_q <= rd_way_q;
				// lowest matching way wins; on a miss take the LRU way
				if (cmp_match) begin
					hit_sel_q <= 1'b1;
					way_sel_q <= cmp_way_q;
				end else if (scan_last) begin
					hit_sel_q <= 1'b0;
					way_sel_q <= lru_cur[0];
				end
			end
			sacl_pkg::ST_UPDATE: begin
				hit           <= hit_sel_q;
				set_index     <= set_ext[sacl_pkg::SET_OUT_W-1:0];
				way_used      <= way_ext[sacl_pkg::WAY_OUT_W-1:0];
				request_count <= write_q ? sacl_pkg::sat_inc(wr_req_q)
					: sacl_pkg::sat_inc(rd_req_q);
				if (write_q) begin
					hit_count <= hit_sel_q ? sacl_pkg::sat_inc(wr_hit_q) : wr_hit_q;
				end else begin
					hit_count <= hit_sel_q ? sacl_pkg::sat_inc(rd_hit_q) : rd_hit_q;
				end
			end
			default: ;
		endcase
	end

	`ASSERT_AT(a_accept_busy, clk, arst_n, (start && !busy) |=> busy, "accept did not raise busy")
	`ASSERT_AT(a_hits_le_reqs, clk, arst_n, done |-> (hit_count <= request_count), "hit count above request count")
	`ASSERT_NEVER(a_done_busy, clk, arst_n, done && busy, "result shown while busy")
	`ASSERT_AT(a_scan_ends, clk, arst_n, (state_q == sacl_pkg::ST_SCAN && scan_done) |=> (state_q == sacl_pkg::ST_UPDATE), "scan did not end in update")
endmodule
`default_nettype wire
